// ===== rtl/core/pcc_pkg.sv =====
// pcc_pkg: shared types and constants for the clamped pid controller
// word structs for both channels, register indexes and fixed-point widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam int GAIN_W = 24;
  localparam int MAG_W = 7;
  localparam int ERR_W = 17;
  localparam int SUM_W = 32;
  localparam int RAW_W = 60;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FLOOR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CEILING = 3'd5;

  localparam logic [MAG_W-1:0] CEILING_RESET = 7'd127;

  typedef struct packed {
    logic signed [15:0] measured;
    logic               restart;
  } pcc_in_t;

  typedef struct packed {
    logic signed [7:0] drive;
    logic              limited;
  } pcc_out_t;

endpackage

`default_nettype wire

// ===== rtl/core/pid_controller_clamped_top.sv =====
// pid_controller_clamped_top: pid position controller with magnitude clamp and
// conditional integration; depends on pcc_pkg
//
//   channel | direction | handshake            | word
//   in      | input     | in_vld / in_stall    | pcc_in_t  (measured, restart)
//   out     | output    | out_vld / out_stall  | pcc_out_t (drive, limited)
//   cfg     | input     | cfg_we, cfg_idx      | cfg_wdata (24 bit)
//
// one word per cycle sustained while out_stall is low; out_vld is registered
// the loop through error_sum (multiply, sum, clamp, commit) closes in logic
// between the input register and the output register
// rst_n is synchronous: valids, history and config registers go to their reset values
// an output stall holds the output register; the input register still drains
// into it once it empties, so in_stall only rises when both stages are full
`timescale 1ns / 1ps
`default_nettype none

module pid_controller_clamped_top
  import pcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_vld,
  output logic                       in_stall,
  input  wire pcc_in_t               in_data,
  output logic                       out_vld,
  input  wire logic                  out_stall,
  output pcc_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic signed [15:0]  target_r;
  logic [GAIN_W-1:0]   prop_gain_r;
  logic [GAIN_W-1:0]   integral_gain_r;
  logic [GAIN_W-1:0]   deriv_gain_r;
  logic [MAG_W-1:0]    drive_floor_r;
  logic [MAG_W-1:0]    drive_ceiling_r;

  // pipeline
  logic                a_vld_r;
  pcc_in_t             a_data_r;
  logic                out_vld_r;
  pcc_out_t            out_data_r;
  logic                adv;

  // history
  logic signed [ERR_W-1:0] last_error_r;
  logic signed [SUM_W-1:0] error_sum_r;

  // datapath
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  base_last;
  logic signed [SUM_W-1:0]  base_sum;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  cand_sum;
  logic signed [ERR_W:0]    err_diff;
  logic signed [GAIN_W:0]   pg_s;
  logic signed [GAIN_W:0]   ig_s;
  logic signed [GAIN_W:0]   dg_s;
  logic signed [GAIN_W+ERR_W:0]   p_prod;
  logic signed [GAIN_W+SUM_W:0]   i_prod;
  logic signed [GAIN_W+ERR_W+1:0] d_prod;
  logic signed [RAW_W-1:0]  raw;
  logic                     neg;
  logic signed [MAG_W+1:0]  hi_b;
  logic signed [MAG_W+1:0]  lo_b;
  logic signed [RAW_W-1:0]  hi_q;
  logic signed [RAW_W-1:0]  lo_q;
  logic [RAW_W-1:0]         mag;
  logic [RAW_W-1:0]         mag_rnd;
  logic [7:0]               r8;
  logic                     over_hi;
  logic                     under_lo;
  pcc_out_t                 res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r        <= '0;
      prop_gain_r     <= '0;
      integral_gain_r <= '0;
      deriv_gain_r    <= '0;
      drive_floor_r   <= '0;
      drive_ceiling_r <= CEILING_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TARGET:        target_r        <= cfg_wdata[15:0];
        REG_PROP_GAIN:     prop_gain_r     <= cfg_wdata[GAIN_W-1:0];
        REG_INTEGRAL_GAIN: integral_gain_r <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN:    deriv_gain_r    <= cfg_wdata[GAIN_W-1:0];
        REG_DRIVE_FLOOR:   drive_floor_r   <= cfg_wdata[MAG_W-1:0];
        REG_DRIVE_CEILING: drive_ceiling_r <= cfg_wdata[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign adv      = a_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = a_vld_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      a_vld_r   <= (in_vld && !in_stall) || in_stall;
      out_vld_r <= adv || (out_vld_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld && !in_stall) begin
      a_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  // datapath: error, saturated candidate sum, three products, clamp, round
  always_comb begin
    base_last = a_data_r.restart ? '0 : last_error_r;
    base_sum  = a_data_r.restart ? '0 : error_sum_r;
    err       = {target_r[15], target_r} - {a_data_r.measured[15], a_data_r.measured};
    sum_wide  = {base_sum[SUM_W-1], base_sum} + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      cand_sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      cand_sum = sum_wide[SUM_W-1:0];
    end
    err_diff = {err[ERR_W-1], err} - {base_last[ERR_W-1], base_last};

    pg_s   = {1'b0, prop_gain_r};
    ig_s   = {1'b0, integral_gain_r};
    dg_s   = {1'b0, deriv_gain_r};
    p_prod = pg_s * err;
    i_prod = ig_s * cand_sum;
    d_prod = dg_s * err_diff;
    raw    = {{(RAW_W-GAIN_W-ERR_W-1){p_prod[GAIN_W+ERR_W]}}, p_prod}
           + {{(RAW_W-GAIN_W-SUM_W-1){i_prod[GAIN_W+SUM_W]}}, i_prod}
           + {{(RAW_W-GAIN_W-ERR_W-2){d_prod[GAIN_W+ERR_W+1]}}, d_prod};

    // window flips with the sign; zero counts as positive
    neg  = raw[RAW_W-1];
    hi_b = neg ? -$signed({2'b00, drive_floor_r})   : $signed({2'b00, drive_ceiling_r});
    lo_b = neg ? -$signed({2'b00, drive_ceiling_r}) : $signed({2'b00, drive_floor_r});
    hi_q = {{(RAW_W-MAG_W-2-FRAC_BITS){hi_b[MAG_W+1]}}, hi_b, {FRAC_BITS{1'b0}}};
    lo_q = {{(RAW_W-MAG_W-2-FRAC_BITS){lo_b[MAG_W+1]}}, lo_b, {FRAC_BITS{1'b0}}};
    over_hi  = raw > hi_q;
    under_lo = raw < lo_q;

    // round half away from zero on the magnitude
    mag     = neg ? (~raw + 1'b1) : raw;
    mag_rnd = mag + {{(RAW_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    r8      = mag_rnd[FRAC_BITS+7:FRAC_BITS];

    if (over_hi) begin
      res.drive   = hi_b[7:0];
      res.limited = 1'b1;
    end else if (under_lo) begin
      res.drive   = lo_b[7:0];
      res.limited = 1'b1;
    end else begin
      res.drive   = neg ? -r8 : r8;
      res.limited = 1'b0;
    end
  end

  // history commits as the word moves to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
      error_sum_r  <= '0;
    end else if (adv) begin
      last_error_r <= err;
      error_sum_r  <= res.limited ? base_sum : cand_sum;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/pcc_checker.sv =====
// pcc_checker: port-level checks for pid_controller_clamped_top, bound to it below
// depends on pcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcc_checker
  import pcc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_stall,
  input wire logic                  out_vld,
  input wire logic                  out_stall,
  input wire pcc_out_t              out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_stall |=> out_vld && $stable(out_data))
    else $error("stalled output word changed");

  // drive never reaches the unused negative code
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> out_data.drive != -8'sd128)
    else $error("drive out of range");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld)
    else $error("output valid after reset");

  // with the output register empty the input side is never held
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld |-> !in_stall)
    else $error("input stalled while output empty");

endmodule

bind pid_controller_clamped_top pcc_checker u_pcc_checker (.*);

`default_nettype wire
